// ===== design/fsp_pkg.sv =====
// Shared types, codes and constants of the fair-share priority table.
// Used by fsp_mem, fsp_ctrl and fair_share_priority_table_core.
package fsp_pkg;

  localparam int SLOTS_DEF  = 32;
  localparam int QUEUES_DEF = 16;

  localparam int QW   = 4;
  localparam int UW   = 16;
  localparam int FW   = 21;
  localparam int SIW  = 6;

  localparam logic [2:0] REQ_START   = 3'd0;
  localparam logic [2:0] REQ_INHERIT = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_QEXP    = 3'd3;
  localparam logic [2:0] REQ_NICE    = 3'd4;
  localparam logic [2:0] REQ_BALANCE = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_USED = 2'd1;
  localparam logic [1:0] ST_BAD_Q    = 2'd2;
  localparam logic [1:0] ST_BUSY     = 2'd3;

  localparam logic [1:0] REG_USER_QUEUE   = 2'd0;
  localparam logic [1:0] REG_LOWEST_QUEUE = 2'd1;
  localparam logic [1:0] REG_CHARGE_QT    = 2'd2;

  localparam logic [QW-1:0] USER_QUEUE_RST   = 4'd7;
  localparam logic [QW-1:0] LOWEST_QUEUE_RST = 4'd15;
  localparam logic [UW-1:0] CHARGE_QT_RST    = 16'd200;

  typedef struct packed {
    logic [QW-1:0] queue;
    logic [QW-1:0] max_queue;
    logic [UW-1:0] group;
    logic [UW-1:0] quantum;
    logic [UW-1:0] p_use;
    logic [UW-1:0] g_use;
    logic [FW-1:0] fss;
  } fsp_rec_t;

  typedef struct packed {
    logic [QW-1:0] user_queue;
    logic [QW-1:0] lowest_queue;
    logic [UW-1:0] charge_qt;
  } fsp_cfg_t;

  // Usage charge that sticks at the top of the 16-bit range.
  function automatic logic [UW-1:0] sat_add(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [UW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UW] ? {UW{1'b1}} : s[UW-1:0];
  endfunction

endpackage

// ===== design/fsp_mem.sv =====
// Slot record memory: one write port, one read port with registered data.
// Depends on fsp_pkg for the record type.
module fsp_mem #(
  parameter int SLOTS = fsp_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic [$clog2(SLOTS)-1:0]  raddr,
  output fsp_pkg::fsp_rec_t         rdata,
  input  logic                      we,
  input  logic [$clog2(SLOTS)-1:0]  waddr,
  input  fsp_pkg::fsp_rec_t         wdata
);

  fsp_pkg::fsp_rec_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fsp_ctrl.sv =====
// Request sequencer: checks, read-modify-write walks over the slot memory,
// group counting and the schedule command broadcast. Depends on fsp_pkg, fsp_mem.
module fsp_ctrl #(
  parameter int SLOTS  = fsp_pkg::SLOTS_DEF,
  parameter int QUEUES = fsp_pkg::QUEUES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fsp_pkg::fsp_cfg_t        cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               req_type,
  input  logic [fsp_pkg::SIW-1:0]  slot,
  input  logic [fsp_pkg::SIW-1:0]  parent_slot,
  input  logic [fsp_pkg::UW-1:0]   group,
  input  logic [7:0]               max_queue,
  input  logic [fsp_pkg::UW-1:0]   quantum,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [fsp_pkg::SIW-1:0]  target_slot,
  output logic [fsp_pkg::QW-1:0]   queue,
  output logic [fsp_pkg::UW-1:0]   quantum_out,
  output logic [fsp_pkg::FW-1:0]   fss_value,
  output logic [1:0]               status,
  output logic                     last
);

  localparam int SW = $clog2(SLOTS);
  localparam int GW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_ERR, S_INH_RD, S_INH_P, S_CNT_RDI, S_CNT_I, S_CNT_RDJ, S_CNT_J,
    S_INH_WR, S_QX_RD, S_QX_S, S_QG_RD, S_QG_U, S_DC_RD, S_DC_U, S_RMW_RD, S_RMW_U,
    S_BC_RD, S_BC_S, S_LF_RD, S_LF_U, S_EM_RD, S_EM_U, S_ONE
  } state_t;

  state_t state;

  logic [2:0]              r_req;
  logic [fsp_pkg::SIW-1:0] r_s;
  logic [fsp_pkg::SIW-1:0] r_p;
  logic [fsp_pkg::UW-1:0]  r_grp;
  logic [7:0]              r_mq;
  logic [fsp_pkg::UW-1:0]  r_qin;
  logic [1:0]              err_st;
  logic [SLOTS-1:0]        in_use;
  logic [SW-1:0]           i;
  logic [SW-1:0]           j;
  logic [GW-1:0]           gcnt;
  logic                    cnt_for_inh;
  logic [fsp_pkg::UW-1:0]  cur_grp;
  logic [fsp_pkg::QW-1:0]  pq;
  logic [fsp_pkg::UW-1:0]  pqt;
  logic [fsp_pkg::UW-1:0]  pgu;
  logic [fsp_pkg::QW-1:0]  bq;
  logic [fsp_pkg::UW-1:0]  bqt;
  logic [fsp_pkg::FW-1:0]  bfss;
  logic [SW-1:0]           lastidx;

  logic [SW-1:0]           raddr;
  fsp_pkg::fsp_rec_t       rdata;
  logic                    we;
  logic [SW-1:0]           waddr;
  fsp_pkg::fsp_rec_t       wdata;

  logic [SW-1:0]           sidx;
  logic [SW-1:0]           pidx;
  logic                    s_ok;
  logic                    s_used;
  logic                    p_used;
  logic                    mq_bad;
  logic                    out_free;
  logic                    load;
  logic                    on_user;
  logic [fsp_pkg::UW+GW-1:0] inh_prod;
  logic [fsp_pkg::UW-1:0]  half_proc;
  logic [fsp_pkg::UW-1:0]  half_grp;
  logic [fsp_pkg::UW+GW-1:0] dc_prod;
  logic [fsp_pkg::FW:0]    dc_sum;

  fsp_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  assign sidx     = r_s[SW-1:0];
  assign pidx     = r_p[SW-1:0];
  assign s_ok     = {1'b0, r_s} < 7'(SLOTS);
  assign s_used   = s_ok && in_use[sidx];
  assign p_used   = ({1'b0, r_p} < 7'(SLOTS)) && in_use[pidx];
  assign mq_bad   = r_mq >= 8'(QUEUES);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign on_user  = in_use[i] && (rdata.queue == cfg.user_queue);

  assign inh_prod  = pgu * gcnt;
  assign half_proc = rdata.p_use >> 1;
  assign half_grp  = rdata.g_use >> 1;
  assign dc_prod   = half_grp * gcnt;
  assign dc_sum    = (fsp_pkg::FW+1)'(half_proc >> 1) + (fsp_pkg::FW+1)'(dc_prod >> 2);

  always_comb begin
    unique case (state)
      S_CNT_RDI, S_CNT_I, S_QG_RD, S_QG_U, S_DC_RD, S_DC_U,
      S_LF_RD, S_LF_U, S_EM_RD, S_EM_U:  raddr = i;
      S_CNT_RDJ, S_CNT_J:                raddr = j;
      S_INH_RD, S_INH_P:                 raddr = pidx;
      default:                           raddr = sidx;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = sidx;
    wdata = rdata;
    load  = 1'b0;
    unique case (state)
      S_CHK: begin
        if (r_req == fsp_pkg::REQ_START && s_ok && !in_use[sidx] && !mq_bad) begin
          we               = 1'b1;
          wdata.queue      = r_mq[fsp_pkg::QW-1:0];
          wdata.max_queue  = r_mq[fsp_pkg::QW-1:0];
          wdata.group      = r_grp;
          wdata.quantum    = r_qin;
          wdata.p_use      = '0;
          wdata.g_use      = '0;
          wdata.fss        = '0;
        end
      end
      S_INH_WR: begin
        we               = 1'b1;
        wdata.queue      = pq;
        wdata.max_queue  = r_mq[fsp_pkg::QW-1:0];
        wdata.group      = r_grp;
        wdata.quantum    = pqt;
        wdata.p_use      = '0;
        wdata.g_use      = pgu;
        wdata.fss        = fsp_pkg::FW'(inh_prod >> 2);
      end
      S_QX_S: begin
        if (rdata.queue != cfg.user_queue && rdata.queue < cfg.lowest_queue) begin
          we          = 1'b1;
          wdata.queue = rdata.queue + 1'b1;
        end
      end
      S_QG_U: begin
        waddr = i;
        if (in_use[i] && rdata.group == cur_grp) begin
          we          = 1'b1;
          wdata.g_use = fsp_pkg::sat_add(rdata.g_use, cfg.charge_qt);
          if (i == sidx) begin
            wdata.p_use = fsp_pkg::sat_add(rdata.p_use, cfg.charge_qt);
          end
        end
      end
      S_DC_U: begin
        waddr = i;
        if (on_user) begin
          we          = 1'b1;
          wdata.p_use = half_proc;
          wdata.g_use = half_grp;
          wdata.fss   = dc_sum[fsp_pkg::FW-1:0];
        end
      end
      S_RMW_U: begin
        if (r_req == fsp_pkg::REQ_NICE) begin
          we              = 1'b1;
          wdata.queue     = r_mq[fsp_pkg::QW-1:0];
          wdata.max_queue = r_mq[fsp_pkg::QW-1:0];
        end else if (rdata.queue > rdata.max_queue) begin
          we          = 1'b1;
          wdata.queue = rdata.queue - 1'b1;
        end
      end
      S_ERR, S_ONE: load = out_free;
      S_EM_U:       load = out_free && on_user;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      out_valid <= 1'b0;
      gcnt      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_req <= req_type;
            r_s   <= slot;
            r_p   <= parent_slot;
            r_grp <= group;
            r_mq  <= max_queue;
            r_qin <= quantum;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (r_req == fsp_pkg::REQ_START || r_req == fsp_pkg::REQ_INHERIT) begin
            if (!s_ok) begin
              err_st <= fsp_pkg::ST_NOT_USED;
              state  <= S_ERR;
            end else if (in_use[sidx]) begin
              err_st <= fsp_pkg::ST_BUSY;
              state  <= S_ERR;
            end else if (mq_bad) begin
              err_st <= fsp_pkg::ST_BAD_Q;
              state  <= S_ERR;
            end else if (r_req == fsp_pkg::REQ_INHERIT) begin
              if (!p_used) begin
                err_st <= fsp_pkg::ST_NOT_USED;
                state  <= S_ERR;
              end else begin
                state <= S_INH_RD;
              end
            end else begin
              in_use[sidx] <= 1'b1;
              state        <= S_BC_RD;
            end
          end else if (r_req > fsp_pkg::REQ_BALANCE) begin
            state <= S_IDLE;
          end else if (!s_used) begin
            err_st <= fsp_pkg::ST_NOT_USED;
            state  <= S_ERR;
          end else if (r_req == fsp_pkg::REQ_STOP) begin
            in_use[sidx] <= 1'b0;
            err_st       <= fsp_pkg::ST_OK;
            state        <= S_ERR;
          end else if (r_req == fsp_pkg::REQ_QEXP) begin
            state <= S_QX_RD;
          end else if (r_req == fsp_pkg::REQ_NICE && mq_bad) begin
            err_st <= fsp_pkg::ST_BAD_Q;
            state  <= S_ERR;
          end else begin
            state <= S_RMW_RD;
          end
        end
        S_ERR: begin
          if (load) begin
            target_slot <= r_s;
            queue       <= '0;
            quantum_out <= '0;
            fss_value   <= '0;
            status      <= err_st;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_INH_RD: state <= S_INH_P;
        S_INH_P: begin
          pq          <= rdata.queue;
          pqt         <= rdata.quantum;
          pgu         <= rdata.g_use;
          i           <= '0;
          gcnt        <= '0;
          cnt_for_inh <= 1'b1;
          state       <= S_CNT_RDI;
        end
        // Distinct groups: slot i counts if no earlier eligible slot shares its group.
        S_CNT_RDI: state <= S_CNT_I;
        S_CNT_I: begin
          if (on_user && i != '0) begin
            cur_grp <= rdata.group;
            j       <= '0;
            state   <= S_CNT_RDJ;
          end else begin
            if (on_user) begin
              gcnt <= gcnt + 1'b1;
            end
            if (i == LAST_IDX) begin
              i     <= '0;
              state <= cnt_for_inh ? S_INH_WR : S_DC_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_CNT_RDI;
            end
          end
        end
        S_CNT_RDJ: state <= S_CNT_J;
        S_CNT_J: begin
          if (in_use[j] && rdata.queue == cfg.user_queue && rdata.group == cur_grp) begin
            if (i == LAST_IDX) begin
              i     <= '0;
              state <= cnt_for_inh ? S_INH_WR : S_DC_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_CNT_RDI;
            end
          end else if (j == i - 1'b1) begin
            gcnt <= gcnt + 1'b1;
            if (i == LAST_IDX) begin
              i     <= '0;
              state <= cnt_for_inh ? S_INH_WR : S_DC_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_CNT_RDI;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_CNT_RDJ;
          end
        end
        S_INH_WR: begin
          in_use[sidx] <= 1'b1;
          state        <= S_BC_RD;
        end
        S_QX_RD: state <= S_QX_S;
        S_QX_S: begin
          if (rdata.queue == cfg.user_queue) begin
            cur_grp <= rdata.group;
            i       <= '0;
            state   <= S_QG_RD;
          end else begin
            state <= S_BC_RD;
          end
        end
        S_QG_RD: state <= S_QG_U;
        S_QG_U: begin
          if (i == LAST_IDX) begin
            i           <= '0;
            gcnt        <= '0;
            cnt_for_inh <= 1'b0;
            state       <= S_CNT_RDI;
          end else begin
            i     <= i + 1'b1;
            state <= S_QG_RD;
          end
        end
        S_DC_RD: state <= S_DC_U;
        S_DC_U: begin
          if (i == LAST_IDX) begin
            state <= S_BC_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_DC_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_U;
        S_RMW_U: begin
          if (r_req == fsp_pkg::REQ_NICE || rdata.queue > rdata.max_queue) begin
            state <= S_BC_RD;
          end else begin
            err_st <= fsp_pkg::ST_OK;
            state  <= S_ERR;
          end
        end
        S_BC_RD: state <= S_BC_S;
        S_BC_S: begin
          bq   <= rdata.queue;
          bqt  <= rdata.quantum;
          bfss <= rdata.fss;
          i    <= '0;
          state <= (rdata.queue == cfg.user_queue) ? S_LF_RD : S_ONE;
        end
        S_ONE: begin
          if (load) begin
            target_slot <= r_s;
            queue       <= bq;
            quantum_out <= bqt;
            fss_value   <= bfss;
            status      <= fsp_pkg::ST_OK;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        // First pass finds the highest eligible slot so its command carries last.
        S_LF_RD: state <= S_LF_U;
        S_LF_U: begin
          if (on_user) begin
            lastidx <= i;
          end
          if (i == LAST_IDX) begin
            i     <= '0;
            state <= S_EM_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_LF_RD;
          end
        end
        S_EM_RD: state <= S_EM_U;
        S_EM_U: begin
          if (load) begin
            target_slot <= fsp_pkg::SIW'(i);
            queue       <= bq;
            quantum_out <= bqt;
            fss_value   <= rdata.fss;
            status      <= fsp_pkg::ST_OK;
            last        <= (i == lastidx);
          end
          if (load || !on_user) begin
            if (i == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("result loaded over an unaccepted result");
  a_gcnt_range: assert property (@(posedge clk) disable iff (rst)
    gcnt <= GW'(SLOTS))
    else $error("group count beyond table size");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("memory write while idle");
  a_emit_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_U && load) |-> in_use[i])
    else $error("broadcast to a free slot");
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (state == S_EM_U && load && i == lastidx) |=> state == S_EM_RD || state == S_IDLE)
    else $error("walk did not continue after final command");

endmodule

// ===== design/fair_share_priority_table_core.sv =====
// Top level of the fair-share priority table: register port and instances.
// Depends on fsp_pkg and fsp_ctrl (which holds fsp_mem).
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_stall   req_type slot parent_slot group max_queue quantum
//  command   out        out_valid / out_stall target_slot queue quantum_out fss_value status last
//  config    in         psel penable pwrite   paddr pwdata prdata pready
//
// One request at a time; in_stall is high from acceptance until its walk finishes.
// Each slot visit reads the record RAM and then acts on its registered read data.
// Synchronous reset frees all slots and restores register defaults.
// A stalled command holds the walk until it is taken.
module fair_share_priority_table_core #(
  parameter int SLOTS  = fsp_pkg::SLOTS_DEF,
  parameter int QUEUES = fsp_pkg::QUEUES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               req_type,
  input  logic [fsp_pkg::SIW-1:0]  slot,
  input  logic [fsp_pkg::SIW-1:0]  parent_slot,
  input  logic [fsp_pkg::UW-1:0]   group,
  input  logic [7:0]               max_queue,
  input  logic [fsp_pkg::UW-1:0]   quantum,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [fsp_pkg::SIW-1:0]  target_slot,
  output logic [fsp_pkg::QW-1:0]   queue,
  output logic [fsp_pkg::UW-1:0]   quantum_out,
  output logic [fsp_pkg::FW-1:0]   fss_value,
  output logic [1:0]               status,
  output logic                     last,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  fsp_pkg::fsp_cfg_t cfg;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_queue   <= fsp_pkg::USER_QUEUE_RST;
      cfg.lowest_queue <= fsp_pkg::LOWEST_QUEUE_RST;
      cfg.charge_qt    <= fsp_pkg::CHARGE_QT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        fsp_pkg::REG_USER_QUEUE:   cfg.user_queue   <= pwdata[fsp_pkg::QW-1:0];
        fsp_pkg::REG_LOWEST_QUEUE: cfg.lowest_queue <= pwdata[fsp_pkg::QW-1:0];
        fsp_pkg::REG_CHARGE_QT:    cfg.charge_qt    <= pwdata[fsp_pkg::UW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fsp_pkg::REG_USER_QUEUE:   prdata = 32'(cfg.user_queue);
      fsp_pkg::REG_LOWEST_QUEUE: prdata = 32'(cfg.lowest_queue);
      fsp_pkg::REG_CHARGE_QT:    prdata = 32'(cfg.charge_qt);
      default:                   prdata = '0;
    endcase
  end

  fsp_ctrl #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .slot        (slot),
    .parent_slot (parent_slot),
    .group       (group),
    .max_queue   (max_queue),
    .quantum     (quantum),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .target_slot (target_slot),
    .queue       (queue),
    .quantum_out (quantum_out),
    .fss_value   (fss_value),
    .status      (status),
    .last        (last)
  );

endmodule
